@@ design/rcr_pkg.sv @@
// Shared types, constants and the log2 table generator for the colour
// restoration block. Depends on nothing; every file but rcr_checker imports it.
`timescale 1ns / 1ps

package rcr_pkg;

  localparam int FRAC_BITS = 23;
  localparam int X_W       = 24;
  localparam int SUM_W     = 10;
  localparam int TBL_W     = 17;
  localparam int L2_W      = 22;
  localparam int LN_W      = 21;
  localparam int D_W       = 25;
  localparam int MAG_W     = 24;
  localparam int OUT_W     = 24;
  localparam int GAIN_W    = 16;
  localparam int NUM_CH    = 3;

  localparam logic [L2_W-1:0]        Q8_BIAS_Q16    = L2_W'(8 << 16);
  localparam logic [29:0]            LN2_Q30        = 30'd744261118;
  localparam logic signed [D_W-1:0]  LN_FLT_MIN_Q16 = -25'sd5723688;
  localparam logic [MAG_W-1:0]       NEG_LIMIT      = 24'd8388608;
  localparam logic [MAG_W-1:0]       POS_LIMIT      = 24'd8388607;
  localparam logic [OUT_W-1:0]       OUT_MIN        = 24'h800000;
  localparam logic [OUT_W-1:0]       OUT_MAX        = 24'h7FFFFF;

  localparam logic [GAIN_W-1:0] ALPHA_RESET = 16'd32000;
  localparam logic [GAIN_W-1:0] BETA_RESET  = 16'd11776;

  localparam logic REG_GAIN_ALPHA = 1'b0;
  localparam logic REG_GAIN_BETA  = 1'b1;

  typedef struct packed {
    logic [7:0] pixel_ch0;
    logic [7:0] pixel_ch1;
    logic [7:0] pixel_ch2;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] restore_ch0;
    logic signed [OUT_W-1:0] restore_ch1;
    logic signed [OUT_W-1:0] restore_ch2;
  } restore_t;

  typedef struct packed {
    logic                         valid;
    logic                         sum_zero;
    logic [LN_W-1:0]              ln_sum;
    logic [NUM_CH-1:0][LN_W-1:0]  ln_ch;
  } lane_set_t;

  // log2(1 + i / 2^bits) in Q16, found by repeated squaring of a Q30 mantissa.
  function automatic logic [TBL_W-1:0] log2_mantissa(input int i, input int bits);
    logic [63:0]      y;
    logic [TBL_W-1:0] res;
    res = '0;
    if (i >= (1 << bits)) begin
      res = TBL_W'(65536);
    end else begin
      y = (64'd1 << 30) + (64'(i) << (30 - bits));
      for (int k = 1; k <= 16; k++) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          res[16 - k] = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

@@ design/rcr_log_lane.sv @@
// One natural-log lane: leading-one detection, table log2 with linear
// interpolation and scaling by ln 2, three register stages. Uses rcr_pkg.
`timescale 1ns / 1ps

module rcr_log_lane #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                     clk,
  input  logic                     q8_in,
  input  logic [rcr_pkg::X_W-1:0]  m,
  output logic [rcr_pkg::LN_W-1:0] ln
);
  import rcr_pkg::*;

  localparam int SUB_BITS = FRAC_BITS - LOG_TABLE_BITS;
  localparam int TBL_SIZE = (1 << LOG_TABLE_BITS) + 1;
  localparam int PROD_W   = TBL_W + SUB_BITS;

  logic [TBL_W-1:0] tbl [TBL_SIZE];

  for (genvar g = 0; g < TBL_SIZE; g++) begin : g_tbl
    assign tbl[g] = log2_mantissa(g, LOG_TABLE_BITS);
  end

  logic [4:0]                e_c;
  logic [X_W-1:0]            norm_c;
  logic [LOG_TABLE_BITS-1:0] idx_c;
  logic [LOG_TABLE_BITS:0]   idx_lo_c;
  logic [TBL_W-1:0]          lo_c;
  logic [TBL_W-1:0]          hi_c;

  always_comb begin
    e_c = '0;
    for (int k = 1; k < X_W; k++) begin
      if (m[k]) begin
        e_c = 5'(k);
      end
    end
    norm_c   = m << (5'(FRAC_BITS) - e_c);
    idx_c    = norm_c[FRAC_BITS-1 -: LOG_TABLE_BITS];
    idx_lo_c = {1'b0, idx_c};
    lo_c     = tbl[idx_lo_c];
    hi_c     = tbl[idx_lo_c + 1'b1];
  end

  logic [4:0]          e1;
  logic [TBL_W-1:0]    lo1;
  logic [TBL_W-1:0]    diff1;
  logic [SUB_BITS-1:0] r1;
  logic                q81;

  logic [PROD_W-1:0] prod_c;
  logic [L2_W-1:0]   l2_c;

  always_comb begin
    prod_c = PROD_W'(diff1) * PROD_W'(r1);
    l2_c   = L2_W'({e1, 16'b0}) + L2_W'(lo1) + L2_W'(prod_c[PROD_W-1:SUB_BITS])
           - (q81 ? Q8_BIAS_Q16 : '0);
  end

  logic [L2_W-1:0] l2;
  logic [51:0]     ln_prod_c;

  assign ln_prod_c = 52'(l2) * 52'(LN2_Q30) + (52'd1 << 29);

  always_ff @(posedge clk) begin
    e1    <= e_c;
    lo1   <= lo_c;
    diff1 <= hi_c - lo_c;
    r1    <= norm_c[SUB_BITS-1:0];
    q81   <= q8_in;
    l2    <= l2_c;
    ln    <= ln_prod_c[30 +: LN_W];
  end

endmodule

@@ design/rcr_merge.sv @@
// Merging stage: takes the three channel logs and the sum log, forms the
// differences, applies the beta gain with rounding and saturates. Uses rcr_pkg.
`timescale 1ns / 1ps

module rcr_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  rcr_pkg::lane_set_t          lanes,
  input  logic [rcr_pkg::GAIN_W-1:0]  gain_beta,
  output logic                        done,
  output rcr_pkg::restore_t           restore
);
  import rcr_pkg::*;

  logic signed [D_W-1:0] ln_sum_c;
  logic signed [D_W-1:0] d_c [NUM_CH];

  always_comb begin
    ln_sum_c = lanes.sum_zero ? LN_FLT_MIN_Q16 : signed'(D_W'(lanes.ln_sum));
    for (int k = 0; k < NUM_CH; k++) begin
      d_c[k] = signed'(D_W'(lanes.ln_ch[k])) - ln_sum_c;
    end
  end

  logic                v1;
  logic                v2;
  logic [NUM_CH-1:0]   neg1;
  logic [NUM_CH-1:0]   neg2;
  logic [MAG_W-1:0]    mag1 [NUM_CH];
  logic [MAG_W-1:0]    p2   [NUM_CH];
  logic [39:0]         prod_c [NUM_CH];
  logic [OUT_W-1:0]    sat_c  [NUM_CH];

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      prod_c[k] = 40'(mag1[k]) * 40'(gain_beta) + (40'd1 << 15);
      if (neg2[k]) begin
        sat_c[k] = (p2[k] > NEG_LIMIT) ? OUT_MIN : (~p2[k] + 1'b1);
      end else begin
        sat_c[k] = (p2[k] > POS_LIMIT) ? OUT_MAX : p2[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= lanes.valid;
      v2   <= v1;
      done <= v2;
    end
    for (int k = 0; k < NUM_CH; k++) begin
      neg1[k] <= d_c[k][D_W-1];
      mag1[k] <= d_c[k][D_W-1] ? MAG_W'(-d_c[k]) : MAG_W'(d_c[k]);
      neg2[k] <= neg1[k];
      p2[k]   <= prod_c[k][16 +: MAG_W];
    end
    restore.restore_ch0 <= sat_c[0];
    restore.restore_ch1 <= sat_c[1];
    restore.restore_ch2 <= sat_c[2];
  end

endmodule

@@ design/retinex_color_restoration.sv @@
// Top level of the colour restoration block: gain registers, input stage,
// four log lanes and the merging stage. Uses rcr_pkg, rcr_log_lane, rcr_merge.
//
// A pixel transfer takes place at a rising edge with start high and busy low.
// busy is high only while rst is held, so one pixel may enter every clock.
// The result is on restore for exactly one cycle, marked by done; between its
// pixel's transfer and the result lie one input stage, three stages in each
// log lane and three in the merging stage. Throughput is one pixel per clock;
// the three channel lanes and the sum lane run side by side, each with its own
// log2 table, so no resource is shared between pixels.
// The receiver cannot hold results off, and none is needed: the pipeline never
// stalls. Reset is synchronous; it empties the pipeline, so no done follows for
// pixels still in flight, and sets gain_alpha to 125.0 and gain_beta to 46.0.
// The gains are written through wr_en, wr_index and wr_data, one register per
// cycle, and should change only while no pixel is in flight.
`timescale 1ns / 1ps

module retinex_color_restoration #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  rcr_pkg::pixel_t             pixel,
  output logic                        done,
  output rcr_pkg::restore_t           restore,
  input  logic                        wr_en,
  input  logic                        wr_index,
  input  logic [rcr_pkg::GAIN_W-1:0]  wr_data
);
  import rcr_pkg::*;

  logic [GAIN_W-1:0] gain_alpha;
  logic [GAIN_W-1:0] gain_beta;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_alpha <= ALPHA_RESET;
      gain_beta  <= BETA_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_GAIN_ALPHA: gain_alpha <= wr_data;
        REG_GAIN_BETA:  gain_beta  <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic              accept;
  logic [X_W-1:0]    x_next [NUM_CH];
  logic [7:0]        ch_c   [NUM_CH];

  assign accept = start && !busy;

  always_comb begin
    ch_c[0] = pixel.pixel_ch0;
    ch_c[1] = pixel.pixel_ch1;
    ch_c[2] = pixel.pixel_ch2;
    for (int k = 0; k < NUM_CH; k++) begin
      x_next[k] = X_W'({8'b0, gain_alpha} * {16'b0, ch_c[k]}) + X_W'(256);
    end
  end

  logic [X_W-1:0]   x0 [NUM_CH];
  logic [SUM_W-1:0] sum0;
  logic [3:0]       valid;
  logic [2:0]       zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], accept};
    end
    zero <= {zero[1:0], (sum0 == '0)};
    for (int k = 0; k < NUM_CH; k++) begin
      x0[k] <= x_next[k];
    end
    sum0 <= SUM_W'(pixel.pixel_ch0) + SUM_W'(pixel.pixel_ch1) + SUM_W'(pixel.pixel_ch2);
  end

  lane_set_t lanes;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    rcr_log_lane #(
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_lane (
      .clk   (clk),
      .q8_in (1'b1),
      .m     (x0[g]),
      .ln    (lanes.ln_ch[g])
    );
  end

  rcr_log_lane #(
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_sum_lane (
    .clk   (clk),
    .q8_in (1'b0),
    .m     (X_W'(sum0)),
    .ln    (lanes.ln_sum)
  );

  assign lanes.valid    = valid[3];
  assign lanes.sum_zero = zero[2];

  rcr_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lanes     (lanes),
    .gain_beta (gain_beta),
    .done      (done),
    .restore   (restore)
  );

endmodule

@@ design/rcr_checker.sv @@
// Port-level checks for the colour restoration block, bound to its top level.
// Depends only on the top level's handshake ports.
`timescale 1ns / 1ps

module rcr_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_busy_only_in_reset: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy high outside reset");

  a_transfer_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##7 done)
    else $error("pixel transfer without result seven cycles later");

  a_result_has_transfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 7))
    else $error("result without a pixel transfer seven cycles earlier");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe straight after reset");

endmodule

bind retinex_color_restoration rcr_checker u_rcr_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

@@ tb/tb_retinex_color_restoration.sv @@
// Self-checking testbench for retinex_color_restoration: pixels go in through
// the start/busy command port and every result is compared with a local model.
// Depends on rcr_pkg for the pixel and result types and the register indexes.
`timescale 1ns / 1ps

module tb_retinex_color_restoration;
  import rcr_pkg::*;

  localparam int TABLE_BITS   = 8;
  localparam int TABLE_LAST   = 1 << TABLE_BITS;
  localparam int SUB_BITS     = 23 - TABLE_BITS;
  localparam int PIPE_LATENCY = 7;
  localparam longint LN2_FIX        = 744261118;
  localparam longint LN_FLOOR_Q16   = -5723688;
  localparam longint RESTORE_MAX    = 8388607;
  localparam longint RESTORE_MIN    = -8388608;
  localparam int MAX_REPORTS  = 30;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  pixel_t   pixel = '0;
  logic     done;
  restore_t restore;
  logic     wr_en = 1'b0;
  logic     wr_index = REG_GAIN_ALPHA;
  logic [GAIN_W-1:0] wr_data = '0;

  retinex_color_restoration #(.LOG_TABLE_BITS(TABLE_BITS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .done(done), .restore(restore), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always #1 clk = ~clk;

  longint   log2_frac [0:TABLE_LAST];
  longint   alpha_gain = 32000;
  longint   beta_gain = 11776;
  restore_t restore_q [$];
  int       mismatch_count = 0;

  function automatic longint table_entry(input int i);
    longint unsigned y;
    longint frac;
    frac = 0;
    if (i >= TABLE_LAST) begin
      return 65536;
    end
    y = (64'd1 << 30) + (longint'(i) << (30 - TABLE_BITS));
    for (int k = 1; k <= 16; k++) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        frac = frac | (longint'(1) << (16 - k));
      end
    end
    return frac;
  endfunction

  function automatic longint log2_fixed(input longint m);
    int     e;
    longint f, idx, r, lo, hi;
    e = 0;
    for (int b = 0; b < 24; b++) begin
      if (m[b]) e = b;
    end
    f = (m << (23 - e)) & 64'h7FFFFF;
    idx = f >> SUB_BITS;
    r = f & ((64'd1 << SUB_BITS) - 1);
    lo = log2_frac[idx];
    hi = log2_frac[idx + 1];
    return (longint'(e) << 16) + lo + (((hi - lo) * r) >> SUB_BITS);
  endfunction

  function automatic longint ln_fixed(input longint l2);
    return (l2 * LN2_FIX + (64'd1 << 29)) >>> 30;
  endfunction

  function automatic logic [OUT_W-1:0] channel_factor(input logic [7:0] c,
                                                       input longint ln_sum);
    longint x, ln_x, d, mag, p, v;
    x = alpha_gain * longint'(c) + 256;
    ln_x = ln_fixed(log2_fixed(x) - (64'd8 << 16));
    d = ln_x - ln_sum;
    mag = (d < 0) ? -d : d;
    p = (mag * beta_gain + 32768) >>> 16;
    if (d < 0) begin
      v = (p > -RESTORE_MIN) ? RESTORE_MIN : -p;
    end else begin
      v = (p > RESTORE_MAX) ? RESTORE_MAX : p;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic restore_t predict_restore(input pixel_t p);
    longint   sum, ln_sum;
    restore_t r;
    sum = longint'(p.pixel_ch0) + longint'(p.pixel_ch1) + longint'(p.pixel_ch2);
    ln_sum = (sum == 0) ? LN_FLOOR_Q16 : ln_fixed(log2_fixed(sum));
    r.restore_ch0 = channel_factor(p.pixel_ch0, ln_sum);
    r.restore_ch1 = channel_factor(p.pixel_ch1, ln_sum);
    r.restore_ch2 = channel_factor(p.pixel_ch2, ln_sum);
    return r;
  endfunction

  initial begin
    for (int i = 0; i <= TABLE_LAST; i++) begin
      log2_frac[i] = table_entry(i);
    end
  end

  task automatic report_field(input string name, input logic [OUT_W-1:0] expv,
                              input logic [OUT_W-1:0] gotv);
    if (gotv !== expv) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                 $signed(expv), $signed(gotv));
      end
    end
  endtask

  // Results are checked before the pixel taken at the same edge is predicted.
  always @(posedge clk) begin
    restore_t want;
    if (done) begin
      if (restore_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, restore);
        end
      end else begin
        want = restore_q.pop_front();
        report_field("restore_ch0", want.restore_ch0, restore.restore_ch0);
        report_field("restore_ch1", want.restore_ch1, restore.restore_ch1);
        report_field("restore_ch2", want.restore_ch2, restore.restore_ch2);
      end
    end
    if (start && !busy) begin
      restore_q.push_back(predict_restore(pixel));
    end
  end

  task automatic send_pixel(input pixel_t p);
    @(negedge clk);
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      pixel <= pixel_t'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic int random_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Waits until every pixel in flight has produced its result.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    wait (restore_q.size() == 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_gain(input logic idx, input logic [GAIN_W-1:0] value);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    if (idx == REG_GAIN_ALPHA) alpha_gain = longint'(value);
    else beta_gain = longint'(value);
    @(negedge clk);
    wr_en <= 1'b0;
    wr_data <= GAIN_W'($urandom);
  endtask

  task automatic send_rgb(input logic [7:0] c0, input logic [7:0] c1,
                          input logic [7:0] c2);
    pixel_t p;
    p.pixel_ch0 = c0;
    p.pixel_ch1 = c1;
    p.pixel_ch2 = c2;
    send_pixel(p);
    idle_cycles($urandom_range(0, 1));
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     mode;
    p = pixel_t'($urandom);
    mode = $urandom_range(0, 9);
    case (mode)
      5: begin
        p.pixel_ch0 = 8'($urandom_range(0, 3));
        p.pixel_ch1 = 8'($urandom_range(0, 3));
        p.pixel_ch2 = 8'($urandom_range(0, 3));
      end
      6: begin
        p.pixel_ch0 = $urandom_range(0, 1) ? p.pixel_ch0 : 8'd0;
        p.pixel_ch1 = $urandom_range(0, 1) ? 8'd0 : p.pixel_ch1;
        p.pixel_ch2 = 8'd0;
      end
      7: p = '0;
      8: begin
        p.pixel_ch1 = p.pixel_ch0;
        p.pixel_ch2 = p.pixel_ch0;
      end
      9: begin
        p.pixel_ch0 = 8'($urandom_range(250, 255));
        p.pixel_ch1 = 8'($urandom_range(250, 255));
        p.pixel_ch2 = 8'($urandom_range(0, 255));
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return GAIN_W'($urandom_range(1, 512));
    return GAIN_W'($urandom);
  endfunction

  // The gains still hold their reset values here.
  task automatic test_reset_gains();
    send_rgb(8'd0, 8'd0, 8'd0);
    send_rgb(8'd255, 8'd255, 8'd255);
    send_rgb(8'd255, 8'd0, 8'd0);
    send_rgb(8'd0, 8'd255, 8'd0);
    send_rgb(8'd0, 8'd0, 8'd255);
    send_rgb(8'd1, 8'd0, 8'd0);
    send_rgb(8'd1, 8'd1, 8'd1);
    send_rgb(8'd128, 8'd64, 8'd32);
    send_rgb(8'd170, 8'd85, 8'd254);
    send_rgb(8'd255, 8'd1, 8'd0);
    settle();
  endtask

  task automatic test_gain_extremes();
    logic [GAIN_W-1:0] alphas [4] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd1};
    logic [GAIN_W-1:0] betas  [4] = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd1};
    for (int s = 0; s < 4; s++) begin
      write_gain(REG_GAIN_ALPHA, alphas[s]);
      write_gain(REG_GAIN_BETA, betas[s]);
      send_rgb(8'd0, 8'd0, 8'd0);
      send_rgb(8'd255, 8'd0, 8'd0);
      send_rgb(8'd1, 8'd255, 8'd255);
      settle();
    end
  endtask

  task automatic test_random_pixels(input int phases, input int per_phase);
    bit burst;
    for (int ph = 0; ph < phases; ph++) begin
      if (ph > 0) begin
        if ($urandom_range(0, 1)) begin
          write_gain(REG_GAIN_BETA, random_gain());
          write_gain(REG_GAIN_ALPHA, random_gain());
        end else begin
          write_gain(REG_GAIN_ALPHA, random_gain());
          write_gain(REG_GAIN_BETA, random_gain());
        end
      end
      burst = 1'b0;
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 19) == 0) burst = ~burst;
        send_pixel(random_pixel());
        idle_cycles(random_gap(burst));
      end
      settle();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_gains();
    test_gain_extremes();
    write_gain(REG_GAIN_ALPHA, 16'd32000);
    write_gain(REG_GAIN_BETA, 16'd11776);
    test_random_pixels(10, 100);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && restore_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
